### sv/slm_pkg.sv
// Shared constants, operation codes and inter-module types for the sorted list merge block.
package slm_pkg;

    localparam int DEPTH     = 32;
    localparam int DATA_W    = 32;
    localparam int LIDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int BUF_DEPTH = 2 * DEPTH;
    localparam int BIDX_W    = $clog2(BUF_DEPTH);
    localparam int TOT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [1:0] OP_MERGE         = 2'd2;

    // Write into the merge buffer.
    typedef struct packed {
        logic              en;
        logic [BIDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_buf_wr;

    // Request to the emit stage once the buffer holds a merged sequence.
    typedef struct packed {
        logic             start;
        logic [TOT_W-1:0] total;
        logic             ovf;
    } t_emit_req;

endpackage

### sv/slm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/slm_merge.sv
// List storage, append handling and the top-down merge into the merge buffer.
module slm_merge import slm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_emit_busy,
    output t_buf_wr                  o_buf_wr,
    output t_emit_req                o_emit_req
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD0 = 3'd1;
    localparam logic [2:0] S_LOAD1 = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt1, n_cnt1;
    logic [CNT_W-1:0]  r_cnt2, n_cnt2;
    logic              r_dropped, n_dropped;
    logic              r_start, n_start;
    logic [CNT_W-1:0]  r_c1, n_c1;
    logic [CNT_W-1:0]  r_c2, n_c2;
    logic [DATA_W-1:0] r_h1, n_h1;
    logic [DATA_W-1:0] r_h2, n_h2;
    logic [TOT_W-1:0]  r_pos, n_pos;
    logic [TOT_W-1:0]  r_total, n_total;
    logic              r_ovf, n_ovf;

    logic              accept;
    logic              take1;
    logic              merging;
    logic              list_rd_en;
    logic [TOT_W-1:0]  cnt_sum;
    logic [CNT_W-1:0]  rd_idx1;
    logic [CNT_W-1:0]  rd_idx2;
    logic              wr1_en;
    logic              wr2_en;
    logic [DATA_W-1:0] rd_data1;
    logic [DATA_W-1:0] rd_data2;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign merging = (r_state == S_MERGE);
    assign cnt_sum = TOT_W'(r_cnt1) + TOT_W'(r_cnt2);

    // Take the larger tail; a tie goes to the second list.
    assign take1 = (r_c1 != '0) && ((r_c2 == '0) || ($signed(r_h1) > $signed(r_h2)));

    // Appends only write while the list still has room.
    assign wr1_en = accept && (i_op == OP_APPEND_FIRST) && (r_cnt1 < CNT_W'(DEPTH));
    assign wr2_en = accept && (i_op == OP_APPEND_SECOND) && (r_cnt2 < CNT_W'(DEPTH));

    // The first read fetches each tail; later reads prefetch the entry below the tail.
    assign list_rd_en = (r_state == S_LOAD0) || (r_state == S_LOAD1) || merging;
    assign rd_idx1    = (r_state == S_LOAD0) ? (r_c1 - CNT_W'(1)) : (n_c1 - CNT_W'(2));
    assign rd_idx2    = (r_state == S_LOAD0) ? (r_c2 - CNT_W'(1)) : (n_c2 - CNT_W'(2));

    slm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_first_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr1_en),
        .i_wr_addr (r_cnt1[LIDX_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (list_rd_en),
        .i_rd_addr (rd_idx1[LIDX_W-1:0]),
        .o_rd_data (rd_data1)
    );

    slm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_second_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr2_en),
        .i_wr_addr (r_cnt2[LIDX_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (list_rd_en),
        .i_rd_addr (rd_idx2[LIDX_W-1:0]),
        .o_rd_data (rd_data2)
    );

    // Next-state logic for the sequencer and the working registers.
    always_comb begin
        n_state   = r_state;
        n_cnt1    = r_cnt1;
        n_cnt2    = r_cnt2;
        n_dropped = r_dropped;
        n_start   = 1'b0;
        n_c1      = r_c1;
        n_c2      = r_c2;
        n_h1      = r_h1;
        n_h2      = r_h2;
        n_pos     = r_pos;
        n_total   = r_total;
        n_ovf     = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_APPEND_FIRST: begin
                            if (wr1_en) begin
                                n_cnt1 = r_cnt1 + CNT_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        OP_APPEND_SECOND: begin
                            if (wr2_en) begin
                                n_cnt2 = r_cnt2 + CNT_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        OP_MERGE: begin
                            n_c1      = r_cnt1;
                            n_c2      = r_cnt2;
                            n_pos     = cnt_sum;
                            n_total   = cnt_sum;
                            n_ovf     = r_dropped;
                            n_dropped = 1'b0;
                            n_cnt1    = '0;
                            n_cnt2    = '0;
                            if (cnt_sum == '0) begin
                                n_state = S_WAIT;
                                n_start = 1'b1;
                            end else begin
                                n_state = S_LOAD0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD0: begin
                n_state = S_LOAD1;
            end
            S_LOAD1: begin
                n_h1    = rd_data1;
                n_h2    = rd_data2;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (take1) begin
                    n_c1 = r_c1 - CNT_W'(1);
                    n_h1 = rd_data1;
                end else begin
                    n_c2 = r_c2 - CNT_W'(1);
                    n_h2 = rd_data2;
                end
                n_pos = r_pos - TOT_W'(1);
                if (r_pos == TOT_W'(1)) begin
                    n_state = S_WAIT;
                    n_start = 1'b1;
                end
            end
            S_WAIT: begin
                if (!r_start && !i_emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt1    <= '0;
            r_cnt2    <= '0;
            r_dropped <= 1'b0;
            r_start   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt1    <= n_cnt1;
            r_cnt2    <= n_cnt2;
            r_dropped <= n_dropped;
            r_start   <= n_start;
        end
    end

    // Working registers of the merge.
    always_ff @(posedge i_clk) begin
        r_c1    <= n_c1;
        r_c2    <= n_c2;
        r_h1    <= n_h1;
        r_h2    <= n_h2;
        r_pos   <= n_pos;
        r_total <= n_total;
        r_ovf   <= n_ovf;
    end

    // Positions are written from the top down.
    assign o_buf_wr.en   = merging;
    assign o_buf_wr.addr = BIDX_W'(r_pos - TOT_W'(1));
    assign o_buf_wr.data = take1 ? r_h1 : r_h2;

    assign o_emit_req.start = r_start;
    assign o_emit_req.total = r_total;
    assign o_emit_req.ovf   = r_ovf;

endmodule

### sv/slm_emit.sv
// Reads the merge buffer from the lowest position upwards and drives the result channel.
module slm_emit import slm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_emit_req                i_emit_req,
    output logic                     o_busy,
    output logic                     o_rd_en,
    output logic [BIDX_W-1:0]        o_rd_addr,
    input  logic [DATA_W-1:0]        i_rd_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_merged_value,
    output logic                     o_last,
    output logic                     o_empty_res,
    output logic                     o_overflow
);

    logic              r_busy;
    logic [TOT_W-1:0]  r_k;
    logic [TOT_W-1:0]  r_tot;
    logic              r_ovf;

    // Read in flight, output register and skid register.
    logic              r_pend;
    logic              r_pend_last;
    logic              r_pend_empty;
    logic              r_pend_ovf;
    logic              r_ov;
    logic [DATA_W-1:0] r_o_data;
    logic              r_o_last;
    logic              r_o_empty;
    logic              r_o_ovf;
    logic              r_sv;
    logic [DATA_W-1:0] r_s_data;
    logic              r_s_last;
    logic              r_s_empty;
    logic              r_s_ovf;

    logic [TOT_W-1:0]  n_emit;
    logic              is_last;
    logic [1:0]        occ;
    logic [1:0]        occ_after;
    logic              xfer;
    logic              issue;
    logic              out_free;
    logic [DATA_W-1:0] pend_data;

    // An empty merge still yields one result.
    assign n_emit  = (r_tot == '0) ? TOT_W'(1) : r_tot;
    assign is_last = (r_k == (n_emit - TOT_W'(1)));

    // A read is issued only when a slot is sure to be free when its data returns.
    assign occ       = 2'(r_ov) + 2'(r_sv) + 2'(r_pend);
    assign xfer      = r_ov && !i_stall;
    assign occ_after = occ - 2'(xfer);
    assign issue     = r_busy && (occ_after < 2'd2);
    assign out_free  = !r_ov || !i_stall;
    assign pend_data = r_pend_empty ? '0 : i_rd_data;

    assign o_rd_en   = issue;
    assign o_rd_addr = r_k[BIDX_W-1:0];

    // Read sequencing over the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_emit_req.start) begin
            r_busy <= 1'b1;
        end else if (issue && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit_req.start) begin
            r_k   <= '0;
            r_tot <= i_emit_req.total;
            r_ovf <= i_emit_req.ovf;
        end else if (issue) begin
            r_k <= r_k + TOT_W'(1);
        end
    end

    // Valid flags of the read in flight, the output register and the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
            r_sv   <= 1'b0;
        end else begin
            r_pend <= issue;
            if (out_free) begin
                r_ov <= r_sv || r_pend;
                r_sv <= r_sv && r_pend;
            end else if (r_pend) begin
                r_sv <= 1'b1;
            end
        end
    end

    // Payload of the read in flight, the output register and the skid register.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last  <= is_last;
            r_pend_empty <= (r_tot == '0);
            r_pend_ovf   <= r_ovf;
        end
        if (out_free) begin
            if (r_sv) begin
                r_o_data  <= r_s_data;
                r_o_last  <= r_s_last;
                r_o_empty <= r_s_empty;
                r_o_ovf   <= r_s_ovf;
                r_s_data  <= pend_data;
                r_s_last  <= r_pend_last;
                r_s_empty <= r_pend_empty;
                r_s_ovf   <= r_pend_ovf;
            end else begin
                r_o_data  <= pend_data;
                r_o_last  <= r_pend_last;
                r_o_empty <= r_pend_empty;
                r_o_ovf   <= r_pend_ovf;
            end
        end else if (r_pend) begin
            r_s_data  <= pend_data;
            r_s_last  <= r_pend_last;
            r_s_empty <= r_pend_empty;
            r_s_ovf   <= r_pend_ovf;
        end
    end

    assign o_busy         = r_busy;
    assign o_valid        = r_ov;
    assign o_merged_value = r_o_data;
    assign o_last         = r_o_last;
    assign o_empty_res    = r_o_empty;
    assign o_overflow     = r_o_ovf;

endmodule

### sv/sorted_list_merge_core.sv
// Top level of the sorted list merge block: merge engine, merge buffer and emit stage.
// Appends are taken whenever the input is not stalled; the input is stalled from a merge
// transfer until the last result of that merge has been read from the buffer, so result-side
// stalls extend it. A merge first fetches the tails of both lists, then fills the buffer
// one element per cycle; the results then come one per cycle while not stalled.
// An empty merge gives its single result.
// Synchronous reset clears the counts, the overflow flag and all valid flags; the list and
// buffer memories are not cleared.
module sorted_list_merge_core import slm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_merged_value,
    output logic                     o_last,
    output logic                     o_empty_res,
    output logic                     o_overflow
);

    t_buf_wr           buf_wr;
    t_emit_req         emit_req;
    logic              emit_busy;
    logic              buf_rd_en;
    logic [BIDX_W-1:0] buf_rd_addr;
    logic [DATA_W-1:0] buf_rd_data;

    // List storage and merge sequencing.
    slm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_emit_busy (emit_busy),
        .o_buf_wr    (buf_wr),
        .o_emit_req  (emit_req)
    );

    // Merge buffer, written top down and read bottom up.
    slm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr.en),
        .i_wr_addr (buf_wr.addr),
        .i_wr_data (buf_wr.data),
        .i_rd_en   (buf_rd_en),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd_data)
    );

    // Result emission.
    slm_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit_req     (emit_req),
        .o_busy         (emit_busy),
        .o_rd_en        (buf_rd_en),
        .o_rd_addr      (buf_rd_addr),
        .i_rd_data      (buf_rd_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_merged_value (o_merged_value),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_overflow     (o_overflow)
    );

endmodule

### sv/slm_checker.sv
// Port-level checks for the sorted list merge block, bound to its top level.
module slm_checker import slm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [1:0]        i_op,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_merged_value,
    input logic              o_last,
    input logic              o_empty_res,
    input logic              o_overflow
);

    // A stalled result holds its value and flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_merged_value) && $stable(o_last)
            && $stable(o_empty_res) && $stable(o_overflow))
        else $error("result changed while stalled");

    // The empty-merge result is always the final one of its merge.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last)
        else $error("empty result without last");

    // A merge transfer closes the input right after it is taken.
    a_merge_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_MERGE) |=> o_stall)
        else $error("input open right after a merge transfer");

    // Within one merge the overflow flag is constant and no empty result appears.
    a_merge_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            !o_valid || (!o_empty_res && (o_overflow == $past(o_overflow))))
        else $error("flags changed within a merge");

endmodule

bind sorted_list_merge_core slm_checker u_slm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_op           (i_op),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_merged_value (o_merged_value),
    .o_last         (o_last),
    .o_empty_res    (o_empty_res),
    .o_overflow     (o_overflow)
);
